// ===== src/jsu_pkg.sv =====
// Shared types, character constants and helper functions for the JSON string unescaper.
// Used by every module under src; depends on nothing else.

package jsu_pkg;

  // Escape decoder phase: plain text, after a backslash, after \u with 0..3 digits.
  typedef enum logic [2:0] {
    PH_TEXT = 3'd0,
    PH_ESC  = 3'd1,
    PH_HEX0 = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5
  } phase_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_END     = 3'd1,
    ST_CTRL    = 3'd2,
    ST_BAD_U   = 3'd3,
    ST_BAD_ESC = 3'd4,
    ST_EARLY   = 3'd5
  } status_t;

  // Characters with a special meaning inside a string body.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Surrogate ranges and UTF-8 length thresholds.
  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] LIM_1BYTE   = 21'h00080;
  localparam logic [20:0] LIM_2BYTE   = 21'h00800;
  localparam logic [20:0] LIM_3BYTE   = 21'h10000;

  // One input beat.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } item_t;

  // Up to four encoded bytes and how many are used.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  // One result beat.
  typedef struct packed {
    enc_t    data;
    status_t status;
  } result_t;

  // Hex digit decode: ok is low for a byte that is not a hex digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Simple escape decode: ok is low for an unknown escape letter.
  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } esc_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // Letters a-f and A-F share their low nibble pattern 1..6.
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic esc_t esc_value(input logic [7:0] c);
    esc_t e;
    e.ok = 1'b1;
    e.ch = c;
    unique case (c) inside
      CH_LOW_B: e.ch = CH_BS;
      CH_LOW_F: e.ch = CH_FF;
      CH_LOW_N: e.ch = CH_LF;
      CH_LOW_R: e.ch = CH_CR;
      CH_LOW_T: e.ch = CH_TAB;
      CH_QUOTE, CH_BSLASH, CH_SLASH: e.ch = c;
      default: e.ok = 1'b0;
    endcase
    return e;
  endfunction

  // UTF-8 encoding of a code point up to 21 bits; unused bytes are zero.
  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e.b = '0;
    e.n = 3'd0;
    if (cp < LIM_1BYTE) begin
      e.b[0] = cp[7:0];
      e.n    = 3'd1;
    end else if (cp < LIM_2BYTE) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.n    = 3'd2;
    end else if (cp < LIM_3BYTE) begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.n    = 3'd3;
    end else begin
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
      e.n    = 3'd4;
    end
    return e;
  endfunction

  // Append one byte after the flushed bytes; the flush never holds more than three.
  function automatic enc_t append_byte(input enc_t head, input logic [7:0] ch);
    enc_t e;
    e = head;
    e.b[head.n[1:0]] = ch;
    e.n = head.n + 3'd1;
    return e;
  endfunction

endpackage

// ===== src/jsu_in_stage.sv =====
// Input register of the JSON string unescaper: holds one accepted beat for the decoder.
// Depends on jsu_pkg for the item type.

module jsu_in_stage
  import jsu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  input  logic  take,
  output logic  held_valid,
  output item_t held
);

  // The register refills in the same cycle it is drained.
  assign item_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

// ===== src/jsu_core.sv =====
// Escape decoder of the JSON string unescaper: phase, hex and pending code point state,
// and the logic that turns one byte into zero or one result. Depends on jsu_pkg.

module jsu_core
  import jsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    take,
  output logic    res_valid,
  output result_t res
);

  phase_t      phase, phase_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [15:0] pending_code, pending_code_next;
  logic        pending_valid, pending_valid_next;

  hex_t        hex;
  esc_t        esc;
  logic [15:0] accum_shift;
  logic        pair;
  logic [20:0] full_cp;
  enc_t        pend_enc;
  enc_t        pair_enc;
  logic [7:0]  c;
  logic        eoi;

  assign c   = item.in_byte;
  assign eoi = item.end_of_input;

  // Shared decode of the current byte against the held state.
  assign hex         = hex_value(c);
  assign esc         = esc_value(c);
  assign accum_shift = {hex_accum[11:0], hex.val};
  assign pair        = pending_valid
                    && pending_code >= HI_SURR_MIN && pending_code <= HI_SURR_MAX
                    && accum_shift >= LO_SURR_MIN && accum_shift <= LO_SURR_MAX;
  assign full_cp     = {1'b0, pending_code[9:0], accum_shift[9:0]} + SUPP_BASE;
  assign pair_enc    = utf8_encode(full_cp);
  assign pend_enc    = pending_valid ? utf8_encode({5'd0, pending_code}) : enc_t'('0);

  // Next state.
  always_comb begin
    phase_next         = phase;
    hex_accum_next     = hex_accum;
    pending_code_next  = pending_code;
    pending_valid_next = pending_valid;
    unique case (phase) inside
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (eoi || !hex.ok) begin
          phase_next         = PH_TEXT;
          hex_accum_next     = '0;
          pending_code_next  = '0;
          pending_valid_next = 1'b0;
        end else if (phase != PH_HEX3) begin
          phase_next     = phase_t'(phase + 3'd1);
          hex_accum_next = accum_shift;
        end else begin
          phase_next     = PH_TEXT;
          hex_accum_next = '0;
          if (pair) begin
            pending_code_next  = '0;
            pending_valid_next = 1'b0;
          end else begin
            pending_code_next  = accum_shift;
            pending_valid_next = 1'b1;
          end
        end
      end
      PH_ESC: begin
        if (!eoi && c == CH_LOW_U) begin
          phase_next     = PH_HEX0;
          hex_accum_next = '0;
        end else begin
          // Both a decoded escape and an error leave nothing pending.
          phase_next         = PH_TEXT;
          pending_code_next  = '0;
          pending_valid_next = 1'b0;
          if (eoi || !esc.ok) begin
            hex_accum_next = '0;
          end
        end
      end
      default: begin
        if (eoi || c == CH_QUOTE || c <= CH_CTRL_MAX) begin
          phase_next         = PH_TEXT;
          hex_accum_next     = '0;
          pending_code_next  = '0;
          pending_valid_next = 1'b0;
        end else if (c == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else begin
          phase_next         = PH_TEXT;
          pending_code_next  = '0;
          pending_valid_next = 1'b0;
        end
      end
    endcase
  end

  // Result of the current byte.
  always_comb begin
    res_valid  = 1'b0;
    res.data   = '0;
    res.status = ST_DATA;
    unique case (phase) inside
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (eoi || !hex.ok) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_U;
        end else if (phase == PH_HEX3) begin
          if (pair) begin
            res_valid = 1'b1;
            res.data  = pair_enc;
          end else if (pending_valid) begin
            res_valid = 1'b1;
            res.data  = pend_enc;
          end
        end
      end
      PH_ESC: begin
        if (eoi) begin
          res_valid  = 1'b1;
          res.status = ST_EARLY;
        end else if (c != CH_LOW_U) begin
          res_valid = 1'b1;
          if (esc.ok) begin
            res.data = append_byte(pend_enc, esc.ch);
          end else begin
            res.status = ST_BAD_ESC;
          end
        end
      end
      default: begin
        if (eoi) begin
          res_valid  = 1'b1;
          res.status = ST_EARLY;
        end else if (c == CH_QUOTE) begin
          res_valid  = 1'b1;
          res.data   = pend_enc;
          res.status = ST_END;
        end else if (c <= CH_CTRL_MAX) begin
          res_valid  = 1'b1;
          res.status = ST_CTRL;
        end else if (c != CH_BSLASH) begin
          res_valid = 1'b1;
          res.data  = append_byte(pend_enc, c);
        end
      end
    endcase
  end

  // State advances only when the held beat is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TEXT;
      hex_accum     <= '0;
      pending_code  <= '0;
      pending_valid <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      hex_accum     <= hex_accum_next;
      pending_code  <= pending_code_next;
      pending_valid <= pending_valid_next;
    end
  end

endmodule

// ===== src/jsu_out_stage.sv =====
// Result register of the JSON string unescaper: holds one result beat until taken.
// Depends on jsu_pkg for the result type.

module jsu_out_stage
  import jsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    space,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t held
);

  // Free when empty or when the current beat leaves this cycle.
  assign space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// ===== src/json_string_unescaper.sv =====
// JSON string body unescaper to UTF-8, one byte per input beat.
// Instantiates jsu_in_stage, jsu_core and jsu_out_stage; depends on jsu_pkg.
//
// Usage: feed the bytes of a string body after the opening quote on the item
// channel (in_byte, end_of_input with item_valid/item_ready). Each beat yields
// zero or one result beat on the result channel: up to four UTF-8 bytes in
// byte0..byte3, their count in byte_count and a status code. A closing quote
// gives status string end with any pending \u character flushed; an error
// gives a status with no bytes and restarts at a new string.
// Path: an accepted byte waits in the input register, its result is loaded
// into the result register and stays on the ports until it is taken.
// Throughput: one beat per cycle unless stalled; the decoder reads and updates
// its phase and pending code point state combinationally between the registers.
// Stall: while result_ready is low and the result register is full, the byte in
// the input register waits and item_ready drops once that register is full too.
// Reset: rst empties both registers and sets the decoder state to plain text with
// nothing pending.

module json_string_unescaper
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] byte0,
  output logic [7:0] byte1,
  output logic [7:0] byte2,
  output logic [7:0] byte3,
  output logic [2:0] byte_count,
  output logic [2:0] status
);

  item_t   item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    space;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign item.in_byte      = in_byte;
  assign item.end_of_input = end_of_input;

  // The held beat is decoded when the result register can take its result.
  assign take = held_valid && space;

  jsu_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (take),
    .held_valid (held_valid),
    .held       (held_item)
  );

  jsu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item      (held_item),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  jsu_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (take && res_valid),
    .res          (res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .held         (out_res)
  );

  assign byte0      = out_res.data.b[0];
  assign byte1      = out_res.data.b[1];
  assign byte2      = out_res.data.b[2];
  assign byte3      = out_res.data.b[3];
  assign byte_count = out_res.data.n;
  assign status     = out_res.status;

  // A result never claims more than four bytes.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> byte_count <= 3'd4)
    else $error("byte_count above four");

  // Error results carry no bytes.
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status >= ST_CTRL) |-> (byte_count == 3'd0 && byte0 == 8'd0))
    else $error("error result with bytes");

  // Byte3 is zero whenever fewer than four bytes are used.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && byte_count <= 3'd3) |-> byte3 == 8'd0)
    else $error("unused byte not zero");

  // Plain data results always carry at least one byte.
  a_data_nonempty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_DATA) |-> byte_count != 3'd0)
    else $error("empty data result");

endmodule

// ===== tb/json_string_unescaper_tb.sv =====
// Testbench for json_string_unescaper: directed, back-pressure and random string bodies.
// It predicts each result beat from its own decoder model and checks the beats in order.
// Depends on jsu_pkg and json_string_unescaper only.
`timescale 1ns / 100ps

module json_string_unescaper_tb
  import jsu_pkg::*;
();

  localparam int RESET_CYCLES    = 7;
  localparam int RANDOM_BEATS    = 1450;
  localparam int HOLD_OFF_CYCLES = 200;
  // About 1600 beats, each at worst a long sender gap plus a long receiver stall.
  localparam int CYCLE_LIMIT     = 1_000_000;

  // One decoded result beat as the decoder model sees it.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    status_t         st;
  } utf8_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] byte0, byte1, byte2, byte3;
  logic [2:0] byte_count;
  logic [2:0] status;

  // Decoder model state.
  phase_t      dec_phase = PH_TEXT;
  logic [15:0] dec_hex = '0;
  logic [15:0] held_cp = '0;
  bit          held_valid = 1'b0;

  utf8_beat_t utf8_expect[$];
  int         mismatches = 0;
  int         sent_beats = 0;
  int         cycle_count = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;
  bit         hold_request = 1'b0;
  int         ready_gap = 0;

  json_string_unescaper u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .byte0        (byte0),
    .byte1        (byte1),
    .byte2        (byte2),
    .byte3        (byte3),
    .byte_count   (byte_count),
    .status       (status)
  );

  always #1 clk = ~clk;

  // Decoder model helpers.
  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic utf8_beat_t add_byte(input utf8_beat_t r, input logic [7:0] v);
    r.bytes[r.count[1:0]] = v;
    r.count = r.count + 3'd1;
    return r;
  endfunction

  function automatic utf8_beat_t add_code_point(input utf8_beat_t r, input logic [20:0] cp);
    if (cp < 21'h80) begin
      r = add_byte(r, cp[7:0]);
    end else if (cp < 21'h800) begin
      r = add_byte(r, 8'hC0 | 8'(cp >> 6));
      r = add_byte(r, 8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      r = add_byte(r, 8'hE0 | 8'((cp >> 12) & 21'h0F));
      r = add_byte(r, 8'h80 | 8'((cp >> 6) & 21'h3F));
      r = add_byte(r, 8'h80 | 8'(cp & 21'h3F));
    end else begin
      r = add_byte(r, 8'hF0 | 8'((cp >> 18) & 21'h07));
      r = add_byte(r, 8'h80 | 8'((cp >> 12) & 21'h3F));
      r = add_byte(r, 8'h80 | 8'((cp >> 6) & 21'h3F));
      r = add_byte(r, 8'h80 | 8'(cp & 21'h3F));
    end
    return r;
  endfunction

  task automatic flush_held(inout utf8_beat_t r);
    if (held_valid) r = add_code_point(r, {5'd0, held_cp});
    held_valid = 1'b0;
    held_cp = '0;
  endtask

  task automatic clear_decoder();
    dec_phase = PH_TEXT;
    dec_hex = '0;
    held_cp = '0;
    held_valid = 1'b0;
  endtask

  // An error drops everything held and restarts at a new string.
  task automatic predict_error(input status_t s);
    utf8_beat_t r;
    r = '0;
    r.st = s;
    clear_decoder();
    utf8_expect.push_back(r);
  endtask

  // Advance the decoder model by one accepted beat and queue its result, if any.
  task automatic unescape_predict(input logic [7:0] c, input logic eoi);
    utf8_beat_t  r;
    logic [3:0]  nib;
    logic [15:0] cp;
    logic [7:0]  lit;
    bit          ok;
    r = '0;
    r.st = ST_DATA;
    lit = 8'h00;

    // Inside a \u escape: collect hex digits.
    if (dec_phase >= PH_HEX0 && dec_phase <= PH_HEX3) begin
      ok = hex_nibble(c, nib);
      if (eoi || !ok) begin
        predict_error(ST_BAD_U);
        return;
      end
      dec_hex = {dec_hex[11:0], nib};
      if (dec_phase != PH_HEX3) begin
        dec_phase = phase_t'(dec_phase + 3'd1);
        return;
      end
      cp = dec_hex;
      dec_hex = '0;
      dec_phase = PH_TEXT;
      // A held high surrogate and a new low surrogate join into one character.
      if (held_valid && held_cp >= HI_SURR_MIN && held_cp <= HI_SURR_MAX &&
          cp >= LO_SURR_MIN && cp <= LO_SURR_MAX) begin
        r = add_code_point(r, 21'h10000 + {1'b0, held_cp[9:0], cp[9:0]});
        held_valid = 1'b0;
        held_cp = '0;
      end else begin
        flush_held(r);
        held_cp = cp;
        held_valid = 1'b1;
      end
      if (r.count != 3'd0) utf8_expect.push_back(r);
      return;
    end

    if (eoi) begin
      predict_error(ST_EARLY);
      return;
    end

    // Letter after a backslash.
    if (dec_phase == PH_ESC) begin
      if (c == CH_LOW_U) begin
        dec_phase = PH_HEX0;
        dec_hex = '0;
        return;
      end
      case (c) inside
        CH_LOW_B: lit = CH_BS;
        CH_LOW_F: lit = CH_FF;
        CH_LOW_N: lit = CH_LF;
        CH_LOW_R: lit = CH_CR;
        CH_LOW_T: lit = CH_TAB;
        CH_QUOTE, CH_BSLASH, CH_SLASH: lit = c;
        default: begin
          predict_error(ST_BAD_ESC);
          return;
        end
      endcase
      flush_held(r);
      r = add_byte(r, lit);
      dec_phase = PH_TEXT;
      utf8_expect.push_back(r);
      return;
    end

    // Plain text.
    if (c == CH_QUOTE) begin
      flush_held(r);
      r.st = ST_END;
      clear_decoder();
      utf8_expect.push_back(r);
      return;
    end
    if (c <= CH_CTRL_MAX) begin
      predict_error(ST_CTRL);
      return;
    end
    if (c == CH_BSLASH) begin
      dec_phase = PH_ESC;
      return;
    end
    flush_held(r);
    r = add_byte(r, c);
    utf8_expect.push_back(r);
  endtask

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 2);
    if (p < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  // Send one beat and feed it to the decoder model once it is accepted.
  task automatic send_beat(input logic [7:0] b, input logic eoi);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    in_byte      <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent_beats++;
    unescape_predict(b, eoi);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic send_u_escape(input logic [15:0] cp);
    send_beat(CH_BSLASH, 1'b0);
    send_beat(CH_LOW_U, 1'b0);
    for (int i = 3; i >= 0; i--)
      send_beat(hex_char(cp[4*i +: 4], 1'($urandom_range(0, 1))), 1'b0);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always begin
    @(posedge clk);
    if (hold_request) begin
      hold_request = 1'b0;
      result_ready <= 1'b0;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
    end else if (ready_gap > 0) begin
      result_ready <= 1'b0;
      ready_gap--;
    end else begin
      result_ready <= 1'b1;
      if (rx_idle_on) ready_gap = pick_gap();
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result beat against the oldest expectation.
  always @(posedge clk) begin
    utf8_beat_t want;
    if (!rst && result_valid && result_ready) begin
      if (utf8_expect.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual count %0d status %0d",
                 $time, byte_count, status);
        mismatches++;
      end else begin
        want = utf8_expect.pop_front();
        check_field("byte0", want.bytes[0], byte0);
        check_field("byte1", want.bytes[1], byte1);
        check_field("byte2", want.bytes[2], byte2);
        check_field("byte3", want.bytes[3], byte3);
        check_field("byte_count", want.count, byte_count);
        check_field("status", want.st, status);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, utf8_expect.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Random stimulus pickers.
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(8'h20, 8'hFF));
    while (v == CH_QUOTE || v == CH_BSLASH);
    return v;
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    logic [7:0] letters [8];
    letters = '{CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_QUOTE, CH_BSLASH, CH_SLASH};
    return letters[$urandom_range(0, 7)];
  endfunction

  function automatic logic [15:0] pick_code_point();
    logic [15:0] edges [6];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(0, 6))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      3: return 16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX));
      4: return 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
      5: return edges[$urandom_range(0, 5)];
      default: return 16'($urandom());
    endcase
  endfunction

  // Broken input: control bytes, bad escapes, bad or cut-short \u, raw noise.
  task automatic send_noise();
    logic [7:0] v;
    logic [3:0] nib;
    int         digits;
    case ($urandom_range(0, 4))
      0: send_beat(8'($urandom_range(0, CH_CTRL_MAX)), 1'b0);
      1: begin
        do v = 8'($urandom_range(0, 255));
        while (v == CH_LOW_U || v == CH_LOW_B || v == CH_LOW_F || v == CH_LOW_N ||
               v == CH_LOW_R || v == CH_LOW_T || v == CH_QUOTE || v == CH_BSLASH ||
               v == CH_SLASH);
        send_beat(CH_BSLASH, 1'b0);
        send_beat(v, 1'b0);
      end
      2: begin
        digits = $urandom_range(0, 3);
        send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_LOW_U, 1'b0);
        repeat (digits)
          send_beat(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          send_beat(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          do v = 8'($urandom_range(0, 255));
          while (hex_nibble(v, nib));
          send_beat(v, 1'b0);
        end
      end
      3: send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      default: send_beat(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  // One string body: mostly well-formed pieces, sometimes noise, usually closed by a quote.
  task automatic send_random_string();
    int pieces;
    int kind;
    pieces = $urandom_range(0, 10);
    repeat (pieces) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_beat(pick_text_byte(), 1'b0);
      end else if (kind < 60) begin
        send_beat(CH_BSLASH, 1'b0);
        send_beat(pick_escape_letter(), 1'b0);
      end else if (kind < 80) begin
        send_u_escape(pick_code_point());
      end else if (kind < 90) begin
        send_u_escape(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
        send_u_escape(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
      end else begin
        send_noise();
      end
    end
    kind = $urandom_range(0, 99);
    if (kind < 85) send_beat(CH_QUOTE, 1'b0);
    else if (kind < 92) send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Field extremes, surrogate handling, string end flush and every error kind.
  task automatic test_directed();
    send_beat(8'h20, 1'b0);
    send_beat(8'hFF, 1'b0);
    // High surrogate in mixed case, then its low half: one 4-byte character.
    send_beat(CH_BSLASH, 1'b0);
    send_beat(CH_LOW_U, 1'b0);
    send_beat(8'h44, 1'b0);
    send_beat(8'h38, 1'b0);
    send_beat(8'h33, 1'b0);
    send_beat(8'h64, 1'b0);
    send_u_escape(16'hDE00);
    // Lone low surrogate, flushed as three bytes by the closing quote.
    send_u_escape(16'hDC00);
    send_beat(CH_QUOTE, 1'b0);
    send_beat(8'h00, 1'b0);
    // Control byte after a backslash is a bad escape.
    send_beat(CH_BSLASH, 1'b0);
    send_beat(8'h01, 1'b0);
    // Quote inside \u, then the stream ending inside \u and in plain text.
    send_beat(CH_BSLASH, 1'b0);
    send_beat(CH_LOW_U, 1'b0);
    send_beat(8'h34, 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    send_beat(CH_BSLASH, 1'b0);
    send_beat(CH_LOW_U, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering beats.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_beat(pick_text_byte(), 1'b0);
    send_beat(CH_QUOTE, 1'b0);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_strings();
    int stop_at;
    stop_at = sent_beats + RANDOM_BEATS;
    while (sent_beats < stop_at) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      send_random_string();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_strings();
    // Drain, then allow for the input and result registers to empty.
    item_valid <= 1'b0;
    rx_idle_on = 1'b0;
    while (utf8_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/jsu_pkg.sv
src/jsu_in_stage.sv
src/jsu_core.sv
src/jsu_out_stage.sv
src/json_string_unescaper.sv
tb/json_string_unescaper_tb.sv
